@@ rtl/rtc_datetime_to_epoch_seconds_core_macros.svh @@
// Assertion macros for the datetime-to-epoch block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef RTC_DATETIME_TO_EPOCH_SECONDS_CORE_MACROS_SVH
`define RTC_DATETIME_TO_EPOCH_SECONDS_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define RTC_DTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTC_DTE_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTC_DTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTC_DTE_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/rtc_dte_pkg.sv @@
// Shared types, constants and tables for the datetime-to-epoch block.
// No dependencies.
`timescale 1ns / 1ps

package rtc_dte_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BINARY_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOUR_24_MODE = 2'd1;

  localparam logic [11:0] YEAR_BASE = 12'd1970;
  localparam logic [11:0] YEAR_TOP  = 12'd2200;

  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;

  localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0] DAYS_YEAR      = 9'd365;

  // YEAR_BASE mod 100 and mod 400
  localparam logic [6:0] BASE_MOD100 = 7'd70;
  localparam logic [8:0] BASE_MOD400 = 9'd370;

  typedef struct packed {
    logic        valid;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } rtc_dte_fields_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/rtc_datetime_to_epoch_seconds_core.sv @@
// Top level: config registers, day-count sequencer over one shared adder, output register.
// Depends on rtc_dte_pkg, rtc_dte_decode and the assertion macro header.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | seven raw clock register bytes
//  out     | output    | out_valid / out_stall| valid_res, calendar fields, epoch_seconds
//  cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// A valid transfer walks ST_YEARS, ST_MONTHS, ST_MUL, ST_ADD and ST_FINISH to reach the output
// register; the per-year add of 365/366 days in ST_YEARS makes the year walk the longest step.
// An invalid snapshot goes straight from ST_IDLE to ST_FINISH.
// in_stall is high from acceptance until the result is loaded into the output register,
// so a stalled output register keeps in_stall high while a result waits in ST_FINISH.
// The output register holds while out_stall is high; a new input may be taken meanwhile.
// Synchronous active-low reset clears control state and loads the config defaults.
`timescale 1ns / 1ps
`include "rtc_datetime_to_epoch_seconds_core_macros.svh"

module rtc_datetime_to_epoch_seconds_core import rtc_dte_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_raw_seconds,
  input  logic [7:0]           in_raw_minutes,
  input  logic [7:0]           in_raw_hours,
  input  logic [7:0]           in_raw_day,
  input  logic [7:0]           in_raw_month,
  input  logic [7:0]           in_raw_year,
  input  logic [7:0]           in_raw_century,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_valid_res,
  output logic [11:0]          out_year,
  output logic [3:0]           out_month,
  output logic [4:0]           out_day,
  output logic [4:0]           out_hour,
  output logic [5:0]           out_minute,
  output logic [5:0]           out_second,
  output logic [32:0]          out_epoch_seconds
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } state_t;

  state_t          state_r;
  logic            binary_mode_r;
  logic            hour_24_mode_r;
  rtc_dte_fields_t dec;
  rtc_dte_fields_t fields_r;
  logic [11:0]     k_r;
  logic [6:0]      mod100_r;
  logic [8:0]      mod400_r;
  logic [3:0]      mcnt_r;
  logic            leap_y_r;
  logic [16:0]     days_r;
  logic [33:0]     prod_r;
  logic [16:0]     sod_r;
  logic [32:0]     epoch_r;
  logic            out_valid_r;
  rtc_dte_fields_t out_fields_r;
  logic [32:0]     out_epoch_r;

  logic            in_xfer;
  logic            out_free;
  logic            leap_k;
  logic [8:0]      addend;
  logic [16:0]     days_nxt;

  rtc_dte_decode u_decode (
    .binary_mode  (binary_mode_r),
    .hour_24_mode (hour_24_mode_r),
    .raw_seconds  (in_raw_seconds),
    .raw_minutes  (in_raw_minutes),
    .raw_hours    (in_raw_hours),
    .raw_day      (in_raw_day),
    .raw_month    (in_raw_month),
    .raw_year     (in_raw_year),
    .raw_century  (in_raw_century),
    .fields       (dec)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign leap_k = ((k_r[1:0] == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);

  // shared day adder
  always_comb begin
    if (state_r == ST_YEARS) begin
      addend = leap_k ? DAYS_LEAP_YEAR : DAYS_YEAR;
    end else begin
      addend = 9'(month_len(mcnt_r)) + 9'((mcnt_r == 4'd2) && leap_y_r);
    end
    days_nxt = days_r + 17'(addend);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r  <= 1'b0;
      hour_24_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_BINARY_MODE) begin
        binary_mode_r <= cfg_data;
      end
      if (cfg_index == CFG_HOUR_24_MODE) begin
        hour_24_mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            fields_r <= dec;
            days_r   <= 17'(dec.day) - 17'd1;
            k_r      <= YEAR_BASE;
            mod100_r <= BASE_MOD100;
            mod400_r <= BASE_MOD400;
            mcnt_r   <= 4'd1;
            epoch_r  <= '0;
            state_r  <= dec.valid ? ST_YEARS : ST_FINISH;
          end
        end
        ST_YEARS: begin
          if (k_r == fields_r.year) begin
            leap_y_r <= leap_k;
            state_r  <= ST_MONTHS;
          end else begin
            days_r   <= days_nxt;
            k_r      <= k_r + 12'd1;
            mod100_r <= (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
            mod400_r <= (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
          end
        end
        ST_MONTHS: begin
          if (mcnt_r == fields_r.month) begin
            state_r <= ST_MUL;
          end else begin
            days_r <= days_nxt;
            mcnt_r <= mcnt_r + 4'd1;
          end
        end
        ST_MUL: begin
          prod_r  <= 34'(days_r) * 34'(SEC_PER_DAY);
          sod_r   <= 17'(fields_r.hour) * SEC_PER_HOUR +
                     17'(fields_r.minute) * SEC_PER_MIN + 17'(fields_r.second);
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          epoch_r <= prod_r[32:0] + 33'(sod_r);
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_fields_r <= fields_r.valid ? fields_r : '0;
            out_epoch_r  <= fields_r.valid ? epoch_r : '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valid_res     = out_fields_r.valid;
  assign out_year          = out_fields_r.year;
  assign out_month         = out_fields_r.month;
  assign out_day           = out_fields_r.day;
  assign out_hour          = out_fields_r.hour;
  assign out_minute        = out_fields_r.minute;
  assign out_second        = out_fields_r.second;
  assign out_epoch_seconds = out_epoch_r;

  `RTC_DTE_ASSERT(a_busy_after_xfer, clk, rst_n, in_xfer |=> in_stall, "input taken while busy")
  `RTC_DTE_ASSERT(a_year_walk, clk, rst_n, state_r == ST_YEARS |-> k_r <= fields_r.year, "year overrun")
  `RTC_DTE_ASSERT(a_month_walk, clk, rst_n, state_r == ST_MONTHS |-> mcnt_r <= fields_r.month, "month overrun")
  `RTC_DTE_ASSERT(a_invalid_zero, clk, rst_n, out_valid && !out_valid_res |-> out_epoch_seconds == '0, "not zeroed")
  `RTC_DTE_ASSERT(a_valid_month, clk, rst_n, out_valid && out_valid_res |-> out_month != '0 && out_day != '0, "zero date")

endmodule

@@ rtl/rtc_dte_decode.sv @@
// Front end: PM strip, BCD decode or binary pass-through, 12/24-hour conversion, year build and range check.
// Depends on rtc_dte_pkg.
`timescale 1ns / 1ps

module rtc_dte_decode import rtc_dte_pkg::*; (
  input  logic            binary_mode,
  input  logic            hour_24_mode,
  input  logic [7:0]      raw_seconds,
  input  logic [7:0]      raw_minutes,
  input  logic [7:0]      raw_hours,
  input  logic [7:0]      raw_day,
  input  logic [7:0]      raw_month,
  input  logic [7:0]      raw_year,
  input  logic [7:0]      raw_century,
  output rtc_dte_fields_t fields
);

  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
  endfunction

  logic        pm;
  logic [7:0]  hr_raw;
  logic [7:0]  sec, min, hr_dec, hr, dy, mon, yr, cent;
  logic [11:0] year;
  logic        ok;

  always_comb begin
    pm     = !hour_24_mode && raw_hours[7];
    hr_raw = pm ? {1'b0, raw_hours[6:0]} : raw_hours;

    if (binary_mode) begin
      sec    = raw_seconds;
      min    = raw_minutes;
      hr_dec = hr_raw;
      dy     = raw_day;
      mon    = raw_month;
      yr     = raw_year;
      cent   = raw_century;
    end else begin
      sec    = from_bcd(raw_seconds);
      min    = from_bcd(raw_minutes);
      hr_dec = from_bcd(hr_raw);
      dy     = from_bcd(raw_day);
      mon    = from_bcd(raw_month);
      yr     = from_bcd(raw_year);
      cent   = from_bcd(raw_century);
    end

    hr = hr_dec;
    if (!hour_24_mode) begin
      if (pm && hr_dec != 8'd12) begin
        hr = hr_dec + 8'd12;
      end else if (!pm && hr_dec == 8'd12) begin
        hr = 8'd0;
      end
    end

    priority if (cent == 8'd19) begin
      year = 12'd1900 + 12'(yr);
    end else if (cent == 8'd21) begin
      year = 12'd2100 + 12'(yr);
    end else begin
      year = 12'd2000 + 12'(yr);
    end

    ok = (mon >= 8'd1) && (mon <= 8'd12) && (dy >= 8'd1) && (dy <= 8'd31) &&
         (hr <= 8'd23) && (min <= 8'd59) && (sec <= 8'd59) &&
         (year >= YEAR_BASE) && (year <= YEAR_TOP);

    fields.valid  = ok;
    fields.year   = year;
    fields.month  = mon[3:0];
    fields.day    = dy[4:0];
    fields.hour   = hr[4:0];
    fields.minute = min[5:0];
    fields.second = sec[5:0];
  end

endmodule

@@ tb/rtc_datetime_to_epoch_seconds_core_tb.sv @@
// Testbench for rtc_datetime_to_epoch_seconds_core: drives clock register snapshots in
// all four mode settings and scores every result against a local calendar predictor.
// Depends on rtc_dte_pkg and the block's RTL.
`timescale 1ns / 1ps

module rtc_datetime_to_epoch_seconds_core_tb;
  import rtc_dte_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 75;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [7:0] raw_seconds;
    logic [7:0] raw_minutes;
    logic [7:0] raw_hours;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic [7:0] raw_century;
  } snapshot_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [32:0] epoch_seconds;
  } epoch_result_t;

  class epoch_scoreboard;
    epoch_result_t pending_dates[$];
    int unsigned   mismatches;
    int unsigned   compared;
    int unsigned   valid_seen;

    static function logic [7:0] bcd_value(logic [7:0] v);
      return 8'(v[3:0] + 10 * v[7:4]);
    endfunction

    static function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function epoch_result_t predict_datetime(snapshot_t s, bit bin, bit h24);
      epoch_result_t   r;
      logic [7:0]      sec, mins, hr, dy, mon, yr, cen;
      bit              pm;
      int unsigned     full_year;
      longint unsigned days;
      longint unsigned total;
      int unsigned     mdays [12];
      mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      r = '0;
      pm = 1'b0;
      sec = s.raw_seconds;
      mins = s.raw_minutes;
      hr = s.raw_hours;
      dy = s.raw_day;
      mon = s.raw_month;
      yr = s.raw_year;
      cen = s.raw_century;
      if (!h24 && hr[7]) begin
        pm = 1'b1;
        hr[7] = 1'b0;
      end
      if (!bin) begin
        sec = bcd_value(sec);
        mins = bcd_value(mins);
        hr = bcd_value(hr);
        dy = bcd_value(dy);
        mon = bcd_value(mon);
        yr = bcd_value(yr);
        cen = bcd_value(cen);
      end
      if (!h24) begin
        if (pm && hr != 8'd12) hr = 8'(hr + 8'd12);
        if (!pm && hr == 8'd12) hr = 8'd0;
      end
      full_year = (cen >= 19 && cen <= 21) ? cen * 100 + yr : 2000 + yr;
      if (mon < 1 || mon > 12 || dy < 1 || dy > 31 || hr > 23 || mins > 59 || sec > 59 ||
          full_year < 1970 || full_year > 2200) begin
        return r;
      end
      days = 0;
      for (int unsigned k = 1970; k < full_year; k++) days += leap_year(k) ? 366 : 365;
      for (int unsigned k = 1; k < mon; k++) begin
        days += mdays[k-1];
        if (k == 2 && leap_year(full_year)) days += 1;
      end
      days += dy - 1;
      total = days * 86400 + 64'(hr) * 3600 + 64'(mins) * 60 + 64'(sec);
      r.valid_res = 1'b1;
      r.year = full_year[11:0];
      r.month = mon[3:0];
      r.day = dy[4:0];
      r.hour = hr[4:0];
      r.minute = mins[5:0];
      r.second = sec[5:0];
      r.epoch_seconds = total[32:0];
      return r;
    endfunction

    function void note_snapshot(snapshot_t s, bit bin, bit h24);
      pending_dates.push_back(predict_datetime(s, bin, h24));
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(epoch_result_t got);
      epoch_result_t want;
      if (pending_dates.size() == 0) begin
        report("unexpected result transfer", 1, 0);
        return;
      end
      want = pending_dates.pop_front();
      compared++;
      if (got.valid_res) valid_seen++;
      if (got.valid_res !== want.valid_res) report("valid_res", got.valid_res, want.valid_res);
      if (got.year !== want.year) report("year", got.year, want.year);
      if (got.month !== want.month) report("month", got.month, want.month);
      if (got.day !== want.day) report("day", got.day, want.day);
      if (got.hour !== want.hour) report("hour", got.hour, want.hour);
      if (got.minute !== want.minute) report("minute", got.minute, want.minute);
      if (got.second !== want.second) report("second", got.second, want.second);
      if (got.epoch_seconds !== want.epoch_seconds) begin
        report("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_raw_seconds = '0;
  logic [7:0]           in_raw_minutes = '0;
  logic [7:0]           in_raw_hours = '0;
  logic [7:0]           in_raw_day = '0;
  logic [7:0]           in_raw_month = '0;
  logic [7:0]           in_raw_year = '0;
  logic [7:0]           in_raw_century = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_valid_res;
  logic [11:0]          out_year;
  logic [3:0]           out_month;
  logic [4:0]           out_day;
  logic [4:0]           out_hour;
  logic [5:0]           out_minute;
  logic [5:0]           out_second;
  logic [32:0]          out_epoch_seconds;

  epoch_scoreboard sb = new();
  bit              cfg_bin = 1'b0;
  bit              cfg_h24 = 1'b1;
  int unsigned     burst_left = 0;
  int unsigned     settings_run = 0;
  bit              hold_off_req = 1'b0;
  epoch_result_t   seen;
  snapshot_t       directed_q[$];

  rtc_datetime_to_epoch_seconds_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_seconds    (in_raw_seconds),
    .in_raw_minutes    (in_raw_minutes),
    .in_raw_hours      (in_raw_hours),
    .in_raw_day        (in_raw_day),
    .in_raw_month      (in_raw_month),
    .in_raw_year       (in_raw_year),
    .in_raw_century    (in_raw_century),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_valid_res     (out_valid_res),
    .out_year          (out_year),
    .out_month         (out_month),
    .out_day           (out_day),
    .out_hour          (out_hour),
    .out_minute        (out_minute),
    .out_second        (out_second),
    .out_epoch_seconds (out_epoch_seconds)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic snapshot_t mk(logic [7:0] sec, logic [7:0] mins, logic [7:0] hr,
                                   logic [7:0] dy, logic [7:0] mon, logic [7:0] yr,
                                   logic [7:0] cen);
    return '{sec, mins, hr, dy, mon, yr, cen};
  endfunction

  function automatic logic [7:0] encode_byte(int unsigned v, bit bin);
    return bin ? 8'(v) : 8'((v / 10) * 16 + v % 10);
  endfunction

  function automatic snapshot_t gen_snapshot(bit bin, bit h24);
    snapshot_t   s;
    int unsigned kind, y, h, h12;
    logic [7:0]  cen;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      s = 56'({$urandom, $urandom});
      return s;
    end
    if ($urandom_range(0, 9) < 7) begin
      y = $urandom_range(1970, 2199);
      s.raw_century = encode_byte(y / 100, bin);
      s.raw_year = encode_byte(y % 100, bin);
    end else begin
      s.raw_year = encode_byte($urandom_range(0, bin ? 200 : 99), bin);
      do begin
        cen = 8'($urandom_range(0, 255));
      end while ((bin ? cen : epoch_scoreboard::bcd_value(cen)) inside {[19:21]});
      s.raw_century = cen;
    end
    s.raw_month = encode_byte($urandom_range(1, 12), bin);
    s.raw_day = encode_byte($urandom_range(1, 31), bin);
    s.raw_minutes = encode_byte($urandom_range(0, 59), bin);
    s.raw_seconds = encode_byte($urandom_range(0, 59), bin);
    h = $urandom_range(0, 23);
    if (h24) begin
      s.raw_hours = encode_byte(h, bin);
    end else begin
      h12 = (h % 12 == 0) ? 12 : h % 12;
      s.raw_hours = encode_byte(h12, bin) | (h >= 12 ? 8'h80 : 8'h00);
    end
    if (kind >= 70) begin
      case ($urandom_range(0, 6))
        0: s.raw_seconds = 8'($urandom_range(0, 255));
        1: s.raw_minutes = 8'($urandom_range(0, 255));
        2: s.raw_hours = 8'($urandom_range(0, 255));
        3: s.raw_day = 8'($urandom_range(0, 255));
        4: s.raw_month = 8'($urandom_range(0, 255));
        5: s.raw_year = 8'($urandom_range(0, 255));
        default: s.raw_century = 8'($urandom_range(0, 255));
      endcase
    end
    return s;
  endfunction

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, bit val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_BINARY_MODE) cfg_bin = val;
    else if (idx == CFG_HOUR_24_MODE) cfg_h24 = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_modes(bit bin, bit h24);
    write_cfg(CFG_BINARY_MODE, bin);
    write_cfg(CFG_HOUR_24_MODE, h24);
    settings_run++;
    burst_left = 0;
  endtask

  task automatic send_item(snapshot_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_raw_seconds <= s.raw_seconds;
    in_raw_minutes <= s.raw_minutes;
    in_raw_hours <= s.raw_hours;
    in_raw_day <= s.raw_day;
    in_raw_month <= s.raw_month;
    in_raw_year <= s.raw_year;
    in_raw_century <= s.raw_century;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_snapshot(s, cfg_bin, cfg_h24);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic send_directed;
    while (directed_q.size() != 0) send_item(directed_q.pop_front());
    drain();
  endtask

  // receiver back-pressure: short random runs, quiet stretches, and requested long hold-offs
  initial begin : receiver
    int unsigned run_left;
    bit          stall_val;
    run_left = 0;
    stall_val = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          stall_val = 1'b1;
          run_left = HOLD_CYCLES;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_val = 1'b0;
          run_left = $urandom_range(20, 60);
        end else begin
          stall_val = ($urandom_range(0, 2) == 0);
          run_left = $urandom_range(1, 8);
        end
      end
      out_stall <= stall_val;
      run_left--;
    end
  end

  always @(posedge clk) begin : result_monitor
    if (rst_n && out_valid && !out_stall) begin
      seen.valid_res = out_valid_res;
      seen.year = out_year;
      seen.month = out_month;
      seen.day = out_day;
      seen.hour = out_hour;
      seen.minute = out_minute;
      seen.second = out_second;
      seen.epoch_seconds = out_epoch_seconds;
      sb.check_result(seen);
    end
  end

  initial begin : stimulus
    bit bin, h24;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: BCD, 24-hour
    settings_run++;
    directed_q.push_back(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19));
    directed_q.push_back(mk(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h21));
    directed_q.push_back(mk(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19));
    directed_q.push_back(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    directed_q.push_back(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    directed_q.push_back(mk(8'h30, 8'h15, 8'h12, 8'h29, 8'h02, 8'h24, 8'h00));
    directed_q.push_back(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21));
    directed_q.push_back(mk(8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h23, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h00, 8'h80, 8'h01, 8'h01, 8'h00, 8'h20));
    directed_q.push_back(mk(8'h0A, 8'h09, 8'h23, 8'h15, 8'h06, 8'hA0, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h5F, 8'h10, 8'h15, 8'h06, 8'h10, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h00, 8'h10, 8'h15, 8'h13, 8'h10, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h00, 8'h10, 8'h32, 8'h06, 8'h10, 8'h20));
    send_directed();

    set_modes(1'b1, 1'b1);
    directed_q.push_back(mk(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd200, 8'd0));
    directed_q.push_back(mk(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd201, 8'd0));
    directed_q.push_back(mk(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd70, 8'd19));
    directed_q.push_back(mk(8'd60, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd20));
    send_directed();

    // out-of-range register indexes must leave the modes alone
    write_cfg(CFG_SPARE_2, 1'b1);
    write_cfg(CFG_SPARE_3, 1'b0);
    set_modes(1'b0, 1'b0);
    directed_q.push_back(mk(8'h00, 8'h30, 8'h12, 8'h04, 8'h07, 8'h24, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h30, 8'h92, 8'h04, 8'h07, 8'h24, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h30, 8'h80, 8'h04, 8'h07, 8'h24, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h30, 8'h00, 8'h04, 8'h07, 8'h24, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h30, 8'h91, 8'h04, 8'h07, 8'h24, 8'h20));
    directed_q.push_back(mk(8'h00, 8'h30, 8'h93, 8'h04, 8'h07, 8'h24, 8'h20));
    send_directed();

    set_modes(1'b1, 1'b0);
    directed_q.push_back(mk(8'd5, 8'd6, 8'h8B, 8'd7, 8'd8, 8'd9, 8'd20));
    directed_q.push_back(mk(8'd5, 8'd6, 8'h0C, 8'd7, 8'd8, 8'd9, 8'd20));
    send_directed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        bin = p[0];
        h24 = p[1];
      end else begin
        bin = 1'($urandom_range(0, 1));
        h24 = 1'($urandom_range(0, 1));
      end
      set_modes(bin, h24);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 30 && (p == 1 || p == 6)) hold_off_req = 1'b1;
        send_item(gen_snapshot(bin, h24));
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (sb.pending_dates.size() != 0) begin
      sb.report("results never delivered", 0, sb.pending_dates.size());
    end
    $display("Checked %0d results (%0d valid dates, %0d rejected) over %0d mode settings,",
             sb.compared, sb.valid_seen, sb.compared - sb.valid_seen, settings_run);
    $display("covering BCD and binary bytes in both 12- and 24-hour modes.");
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
